@@ rtl/audio_block_level_meter_unit_defines.svh @@
// Assertion macros used by the audio block level meter back end.
// The using module must provide clk_i and rst_ni.
`ifndef AUDIO_BLOCK_LEVEL_METER_UNIT_DEFINES_SVH
`define AUDIO_BLOCK_LEVEL_METER_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define ABL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ABL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/abl_pkg.sv @@
// Package for the audio block level meter: block summary types, back-end states
// and constants. No dependencies.
package abl_pkg;

  localparam int unsigned MaxSamples = 256;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = 2;
  localparam int unsigned QCntW      = 3;
  localparam int unsigned DivSteps   = 64;
  localparam int unsigned SqrtSteps  = 32;
  localparam int unsigned LogSteps   = 24;
  localparam int unsigned PowerExp   = 54;
  localparam logic signed [16:0] DbSilent = -17'sd30720;
  localparam logic [31:0] DbKQ30 = 32'd3232284966;

  typedef struct packed {
    logic [55:0] sum;
    logic [31:0] peak;
    logic [8:0]  tally;
  } blk_t;

  typedef struct packed {
    logic valid;
    blk_t blk;
  } push_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_NORM,
    ST_LOG,
    ST_MUL,
    ST_RND,
    ST_OUT
  } back_state_e;

endpackage

@@ rtl/abl_sample_if.sv @@
// Sample input channel: valid/ready with one sample and its end-of-block flag.
// Depends on nothing.
interface abl_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

@@ rtl/abl_level_if.sv @@
// Result channel: valid/ready with the RMS, peak, dBFS and sample count of a block.
// Depends on nothing.
interface abl_level_if;
  logic               valid;
  logic               ready;
  logic [31:0]        rms_level;
  logic [31:0]        peak_level;
  logic signed [16:0] level_db;
  logic [8:0]         samples_used;

  modport source (output valid, output rms_level, output peak_level, output level_db,
                  output samples_used, input ready);
  modport sink (input valid, input rms_level, input peak_level, input level_db,
                input samples_used, output ready);
endinterface

@@ rtl/abl_front.sv @@
// Front end: accepts samples, tracks peak and count, squares and accumulates,
// and pushes a block summary on the closing sample. Depends on abl_pkg, abl_sample_if.
module abl_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  abl_sample_if.sink               in_i,
  input  logic [abl_pkg::QCntW-1:0] q_count_i,
  output abl_pkg::push_t           push_o
);
  import abl_pkg::*;

  logic        accept;
  logic        counted;
  logic        neg;
  logic [23:0] s24;
  logic [23:0] smag;
  logic [31:0] amag;
  logic [31:0] peak_next;
  logic [8:0]  tally_next;
  logic [QCntW:0] busy;

  logic [31:0] peak_q;
  logic [8:0]  tally_q;
  logic        a_cnt_q, a_last_q;
  logic [23:0] a_smag_q;
  logic [31:0] a_peak_q;
  logic [8:0]  a_tally_q;
  logic        b_last_q;
  logic [47:0] b_prod_q;
  logic [31:0] b_peak_q;
  logic [8:0]  b_tally_q;
  logic [55:0] sum_q;
  logic [55:0] sum_d;

  always_comb begin
    busy = {1'b0, q_count_i} + (QCntW + 1)'(a_last_q) + (QCntW + 1)'(b_last_q);
    in_i.ready = busy < (QCntW + 1)'(QDepth);
    accept = in_i.valid & in_i.ready;
    counted = tally_q < 9'(MaxSamples);
    neg = in_i.sample[31];
    s24 = in_i.sample[31:8];
    smag = neg ? (24'd0 - s24) : s24;
    amag = neg ? (32'd0 - in_i.sample) : in_i.sample;
    peak_next = (counted && (amag > peak_q)) ? amag : peak_q;
    tally_next = counted ? (tally_q + 9'd1) : tally_q;
    sum_d = sum_q + 56'(b_prod_q);
    push_o.valid = b_last_q;
    push_o.blk.sum = sum_d;
    push_o.blk.peak = b_peak_q;
    push_o.blk.tally = b_tally_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q   <= '0;
      tally_q  <= '0;
      a_cnt_q  <= 1'b0;
      a_last_q <= 1'b0;
      b_last_q <= 1'b0;
      b_prod_q <= '0;
      sum_q    <= '0;
    end else begin
      a_cnt_q  <= accept & counted;
      a_last_q <= accept & in_i.last;
      b_last_q <= a_last_q;
      b_prod_q <= a_cnt_q ? (48'(a_smag_q) * 48'(a_smag_q)) : '0;
      if (accept) begin
        if (in_i.last) begin
          peak_q  <= '0;
          tally_q <= '0;
        end else begin
          peak_q  <= peak_next;
          tally_q <= tally_next;
        end
      end
      sum_q <= b_last_q ? '0 : sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_smag_q  <= smag;
    a_peak_q  <= peak_next;
    a_tally_q <= tally_next;
    b_peak_q  <= a_peak_q;
    b_tally_q <= a_tally_q;
  end

endmodule

@@ rtl/abl_queue.sv @@
// Short queue of block summaries between the front and back ends.
// Depends on abl_pkg.
module abl_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  abl_pkg::push_t            push_i,
  input  logic                      pop_i,
  output abl_pkg::blk_t             head_o,
  output logic [abl_pkg::QCntW-1:0] count_o
);
  import abl_pkg::*;

  blk_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      count_q <= count_q + QCntW'(push_i.valid) - QCntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.blk;
    end
  end

endmodule

@@ rtl/abl_back.sv @@
// Back end: per block divide, square root, log2 and dB scaling, one step per cycle,
// with a registered result. Depends on abl_pkg, abl_level_if and the assertion macros.
`include "audio_block_level_meter_unit_defines.svh"

module abl_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  abl_pkg::blk_t             head_i,
  input  logic [abl_pkg::QCntW-1:0] q_count_i,
  output logic                      pop_o,
  abl_level_if.source               out_o
);
  import abl_pkg::*;

  back_state_e state_q, state_d;

  logic [5:0]  cnt_q;
  logic [63:0] dq_q;
  logic [8:0]  rem_q;
  logic [8:0]  div_n_q;
  logic [31:0] peak_q;
  logic [8:0]  tally_q;
  logic [63:0] sv_q, sr_q, sb_q;
  logic [62:0] pn_q;
  logic [5:0]  e_q;
  logic [30:0] m_q;
  logic [23:0] frac_q;
  logic [61:0] prod_q;
  logic        dneg_q;
  logic [31:0] rms_q;
  logic signed [16:0] db_q;
  logic        zero_q;

  logic [9:0]  rem_sh;
  logic        ge;
  logic [8:0]  rem_d;
  logic [63:0] dq_d;
  logic [63:0] st;
  logic        sge;
  logic [63:0] sr_d;
  logic [61:0] msq;
  logic [31:0] ms;
  logic [5:0]  ex;
  logic [29:0] mag;
  logic [62:0] rnd;
  logic [16:0] qmag;
  logic        last_step;

  always_comb begin
    rem_sh = {rem_q, dq_q[63]};
    ge = rem_sh >= {1'b0, div_n_q};
    rem_d = ge ? 9'(rem_sh - {1'b0, div_n_q}) : rem_sh[8:0];
    dq_d = {dq_q[62:0], ge};
    st = sr_q + sb_q;
    sge = sv_q >= st;
    sr_d = sge ? ((sr_q >> 1) + sb_q) : (sr_q >> 1);
    msq = 62'(m_q) * 62'(m_q);
    ms = msq[61:30];
    ex = 6'(PowerExp) - e_q;
    mag = (ex == 6'd0) ? 30'(frac_q) : ({ex, 24'd0} - 30'(frac_q));
    rnd = 63'(prod_q) + (63'd1 << 45);
    qmag = rnd[62:46];
  end

  always_comb begin
    state_d = state_q;
    pop_o = 1'b0;
    last_step = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_count_i != '0) begin
          pop_o = 1'b1;
          state_d = (head_i.sum == '0) ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV: begin
        last_step = cnt_q == 6'(DivSteps - 1);
        if (last_step) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        last_step = cnt_q == 6'(SqrtSteps - 1);
        if (last_step) begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (pn_q[62]) begin
          state_d = ST_LOG;
        end
      end
      ST_LOG: begin
        last_step = cnt_q == 6'(LogSteps - 1);
        if (last_step) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_RND;
      ST_RND: state_d = ST_OUT;
      ST_OUT: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q || last_step) ? '0 : cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        dq_q    <= {head_i.sum, 8'd0};
        rem_q   <= '0;
        div_n_q <= (head_i.tally == '0) ? 9'd1 : head_i.tally;
        peak_q  <= head_i.peak;
        tally_q <= head_i.tally;
        zero_q  <= head_i.sum == '0;
        rms_q   <= '0;
        db_q    <= DbSilent;
      end
      ST_DIV: begin
        dq_q  <= dq_d;
        rem_q <= rem_d;
        sv_q  <= dq_d << 8;
        sr_q  <= '0;
        sb_q  <= 64'd1 << 62;
        pn_q  <= dq_d[62:0];
        e_q   <= 6'd62;
      end
      ST_SQRT: begin
        if (sge) begin
          sv_q <= sv_q - st;
        end
        sr_q  <= sr_d;
        sb_q  <= sb_q >> 2;
        rms_q <= sr_d[31:0];
      end
      ST_NORM: begin
        if (!pn_q[62]) begin
          pn_q <= pn_q << 1;
          e_q  <= e_q - 6'd1;
        end
        m_q    <= pn_q[62:32];
        frac_q <= '0;
      end
      ST_LOG: begin
        m_q    <= ms[31] ? ms[31:1] : ms[30:0];
        frac_q <= {frac_q[22:0], ms[31]};
      end
      ST_MUL: begin
        prod_q <= 62'(mag) * 62'(DbKQ30);
        dneg_q <= ex != 6'd0;
      end
      ST_RND: db_q <= dneg_q ? -$signed(qmag) : $signed(qmag);
      default: ;
    endcase
  end

  assign out_o.valid        = state_q == ST_OUT;
  assign out_o.rms_level    = rms_q;
  assign out_o.peak_level   = peak_q;
  assign out_o.level_db     = db_q;
  assign out_o.samples_used = tally_q;

  `ABL_ASSERT_IMP(a_silent_result, out_o.valid && zero_q,
    out_o.rms_level == '0 && out_o.level_db == DbSilent, "silent block result wrong")
  `ABL_ASSERT_IMP(a_rem_below_div, state_q == ST_SQRT, rem_q < div_n_q,
    "division remainder not below divisor")
  `ABL_ASSERT_IMP(a_count_nonzero, out_o.valid, out_o.samples_used != '0,
    "result with empty block")
  `ABL_ASSERT_NXT(a_pop_leaves_idle, pop_o, state_q == ST_DIV || state_q == ST_OUT,
    "pop did not start block processing")

endmodule

@@ rtl/audio_block_level_meter_unit.sv @@
// Top level of the audio block level meter: front end, summary queue, back end.
// Depends on abl_pkg, abl_sample_if, abl_level_if, abl_front, abl_queue, abl_back.
//
// The meter takes one signed 32-bit sample per cycle while the summary queue has room
// and closes a block on a sample with last set; samples beyond 256 in a block are
// ignored. Block summaries wait in a four-entry queue, so sampling continues while
// results are computed. Per block the shared back end loads the summary, then runs
// restoring division, square root, normalization, log2 squaring and dB scaling (a
// silent block skips to the output) and waits for the result to be taken.
// A closing sample passes front-end registers a and b before its summary is queued.
module audio_block_level_meter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  abl_sample_if.sink  in_i,
  abl_level_if.source out_o
);
  import abl_pkg::*;

  push_t            push;
  blk_t             head;
  logic [QCntW-1:0] q_count;
  logic             pop;

  abl_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_count_i (q_count),
    .push_o    (push)
  );

  abl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (q_count)
  );

  abl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .q_count_i (q_count),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

@@ tb/audio_block_level_meter_unit_tb.sv @@
// Self-checking testbench for the audio block level meter: drives samples and block
// closes through the sample channel and checks every result against a built-in model.
// Depends on abl_pkg, abl_sample_if, abl_level_if and audio_block_level_meter_unit.
`timescale 1ns / 1ps

module audio_block_level_meter_unit_tb;
  import abl_pkg::*;

  typedef struct packed {
    logic [31:0]        rms;
    logic [31:0]        peak;
    logic signed [16:0] db;
    logic [8:0]         used;
  } level_t;

  typedef struct {
    logic signed [31:0] sample;
    logic               last;
    logic               has_level;
    level_t             level;
  } stim_row_t;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned RandomItems   = 620;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  abl_sample_if in_if ();
  abl_level_if  out_if ();

  audio_block_level_meter_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [55:0] acc_sum;
  logic [31:0] acc_peak;
  logic [8:0]  acc_tally;
  level_t      pending_levels[$];
  stim_row_t   rows[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          sending_done = 1'b0;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;

  function automatic logic [31:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic signed [16:0] power_to_db(logic [63:0] p);
    int          e;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] mag;
    logic [95:0] prod;
    longint      l;
    e    = 63;
    frac = '0;
    while (e > 0 && p[e] == 1'b0) e--;
    m = (e >= 30) ? (p >> (e - 30)) : (p << (30 - e));
    for (int i = 0; i < 24; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac[0] = 1'b1;
        m       = m >> 1;
      end
    end
    l    = longint'(e - 54) * 64'sd16777216 + longint'(frac);
    mag  = (l < 0) ? 64'(-l) : 64'(l);
    prod = (96'(mag) * 96'(DbKQ30) + (96'd1 << 45)) >> 46;
    return (l < 0) ? -17'(prod) : 17'(prod);
  endfunction

  // Folds one sample into the running block and returns 1 with the level on a close.
  function automatic bit meter_sample(input logic signed [31:0] sample, input logic last,
                                      output level_t level);
    logic signed [23:0] top;
    logic [23:0]        top_mag;
    logic [31:0]        abs_mag;
    logic [63:0]        p;
    logic [63:0]        n;
    if (acc_tally < MaxSamples) begin
      top     = sample[31:8];
      top_mag = top[23] ? -top : top;
      abs_mag = sample[31] ? -sample : sample;
      acc_sum = acc_sum + 56'(48'(top_mag) * 48'(top_mag));
      if (abs_mag > acc_peak) acc_peak = abs_mag;
      acc_tally++;
    end
    if (!last) return 1'b0;
    n          = (acc_tally != 0) ? 64'(acc_tally) : 64'd1;
    level.rms  = '0;
    level.db   = DbSilent;
    level.peak = acc_peak;
    level.used = acc_tally;
    if (acc_sum != 0) begin
      p         = (64'(acc_sum) << 8) / n;
      level.rms = int_sqrt(p << 8);
      level.db  = power_to_db(p);
    end
    acc_sum   = '0;
    acc_peak  = '0;
    acc_tally = '0;
    return 1'b1;
  endfunction

  function automatic void add_row(logic signed [31:0] s, logic l, bit has = 1'b0,
                                  level_t lv = '0);
    stim_row_t r;
    r.sample    = s;
    r.last      = l;
    r.has_level = has;
    r.level     = lv;
    rows.push_back(r);
  endfunction

  task automatic send_sample(logic signed [31:0] s, logic l, bit has, level_t typed);
    level_t lv;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    in_if.last   <= l;
    do @(posedge clk_i); while (!in_if.ready);
    if (meter_sample(s, l, lv)) begin
      if (has && lv !== typed) begin
        $display("%0t: table level mismatch: expected %p actual %p", $time, typed, lv);
        errors++;
      end
      pending_levels.push_back(lv);
    end
  endtask

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return $signed(32'($urandom_range(0, 1023))) - 512;
      3: return $signed($urandom()) >>> $urandom_range(0, 30);
      default: return $signed($urandom());
    endcase
  endfunction

  initial begin
    level_t lv;
    int len;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    in_if.last   <= 1'b0;
    acc_sum   = '0;
    acc_peak  = '0;
    acc_tally = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    lv = '{rms: 32'd0, peak: 32'd0, db: DbSilent, used: 9'd1};
    add_row(32'sd0, 1'b1, 1'b1, lv);
    lv = '{rms: 32'd0, peak: 32'd255, db: DbSilent, used: 9'd2};
    add_row(32'sd255, 1'b0);
    add_row(32'sd255, 1'b1, 1'b1, lv);
    lv = '{rms: 32'h80000000, peak: 32'h80000000, db: 17'sd0, used: 9'd1};
    add_row(32'sh80000000, 1'b1, 1'b1, lv);
    add_row(32'sh7fffffff, 1'b1);
    add_row(-32'sd256, 1'b1);
    add_row(32'sd256, 1'b1);
    add_row(32'sh55555555, 1'b0);
    add_row(32'shaaaaaaaa, 1'b1);
    add_row(32'sh12345678, 1'b0);
    add_row(-32'sd1, 1'b0);
    add_row(32'sh40000000, 1'b1);
    foreach (rows[i]) send_sample(rows[i].sample, rows[i].last, rows[i].has_level,
                                  rows[i].level);

    // Overlong full-scale block: the tally stops at its limit.
    lv = '{rms: 32'h80000000, peak: 32'h80000000, db: 17'sd0, used: 9'd256};
    for (int i = 0; i < 260; i++) send_sample(32'sh80000000, i == 259, i == 259, lv);

    for (int k = 0; k < RandomItems; ) begin
      if (k > RandomItems * 8 / 10) calm = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1, 1'b0, lv);
      k += len;
    end
    in_if.valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_off = 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    level_t got;
    level_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{rms: out_if.rms_level, peak: out_if.peak_level, db: out_if.level_db,
              used: out_if.samples_used};
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        if (got.rms !== want.rms) begin
          $display("%0t: rms_level expected %0d actual %0d", $time, want.rms, got.rms);
          errors++;
        end
        if (got.peak !== want.peak) begin
          $display("%0t: peak_level expected %0d actual %0d", $time, want.peak, got.peak);
          errors++;
        end
        if (got.db !== want.db) begin
          $display("%0t: level_db expected %0d actual %0d", $time, want.db, got.db);
          errors++;
        end
        if (got.used !== want.used) begin
          $display("%0t: samples_used expected %0d actual %0d", $time, want.used, got.used);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || hold_off) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_ni);
    wait ((sending_done && pending_levels.size() == 0) || idle_cycles >= WatchdogLimit);
    if (idle_cycles < WatchdogLimit) begin
      repeat (400) @(posedge clk_i);
      if (errors == 0) begin
        $display("audio_block_level_meter_unit regression: pass");
      end else begin
        $display("audio_block_level_meter_unit regression: fail");
      end
    end else begin
      $display("audio_block_level_meter_unit regression: fail");
    end
    $finish;
  end

endmodule
